// ===== rtl/msw_pkg.sv =====
package msw_pkg;

    // fixed-point formats
    localparam int PHASE_FRAC_BITS = 16;
    localparam int SINE_TABLE_BITS = 8;
    localparam int OUT_FRAC_BITS   = 15;

    // cycle fraction and quarter-wave position widths
    localparam int CYC_BITS  = 24;
    localparam int QUAD_BITS = CYC_BITS - 2;
    localparam int FRAC_BITS = QUAD_BITS - SINE_TABLE_BITS;
    localparam int POS_BITS  = QUAD_BITS + 1;
    localparam int IDX_BITS  = SINE_TABLE_BITS + 1;
    localparam int SINE_TOP  = 1 << SINE_TABLE_BITS;

    // waves are Q2.30 in 32 signed bits
    localparam int WAVE_BITS = 32;
    typedef logic signed [WAVE_BITS-1:0] wave_t;
    localparam wave_t Q_ONE = 32'sd1 <<< 30;

    // table entries are 0..1.0 in Q2.30
    localparam int ROM_BITS = 31;
    typedef logic [ROM_BITS-1:0] sine_rom_t [SINE_TOP+1];

    localparam logic [63:0] ROM_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // function select codes
    localparam logic FUNC_WAVE   = 1'b0;
    localparam logic FUNC_WINDOW = 1'b1;

    // morph position: Q16, 0..3
    localparam int MORPH_BITS = 18;

    // quarter-wave table, taylor series truncated at x^15, worked out at elaboration
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        for (int i = 0; i <= SINE_TOP; i++)
        begin
            x  = (64'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
            x2 = (x * x) >> 30;
            t  = ROM_ONE;
            t  = ROM_ONE - ((x2 * t) >> 30) / 64'd210;
            t  = ROM_ONE - ((x2 * t) >> 30) / 64'd156;
            t  = ROM_ONE - ((x2 * t) >> 30) / 64'd110;
            t  = ROM_ONE - ((x2 * t) >> 30) / 64'd72;
            t  = ROM_ONE - ((x2 * t) >> 30) / 64'd42;
            t  = ROM_ONE - ((x2 * t) >> 30) / 64'd20;
            t  = ROM_ONE - ((x2 * t) >> 30) / 64'd6;
            t  = (x * t) >> 30;
            if (t > ROM_ONE)
            begin
                t = ROM_ONE;
            end
            rom[i] = ROM_BITS'(t);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/morphing_shape_waveform.sv =====
// channel   | signals                 | direction | handshake
// ----------+-------------------------+-----------+--------------------------------
// command   | start, func, phase,     | in        | item taken when start && !busy
//           | shape                   |           |
// status    | busy                    | out       | always low
// result    | done, level             | out       | one level per item, done 1 cycle
//
// a new item can be taken every cycle, set by the six-stage pipeline
// (clamp and morph scale multiply, table read, interpolate, blend multiply,
// window multiply, round). rst_n clears the valid bits only, so items in
// flight at reset are dropped. the receiver cannot stall, so nothing holds the
// pipeline and busy stays low.
module morphing_shape_waveform (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                func,
    input  logic signed [23:0]  phase,
    input  logic signed [15:0]  shape,
    output logic                done,
    output logic signed [15:0]  level
);
    import msw_pkg::*;

    // extended phase width, room for 1.0 at any phase format
    localparam int PW = CYC_BITS + 2;
    localparam logic signed [PW-1:0] P_ONE     = PW'(64'd1 << PHASE_FRAC_BITS);
    localparam logic [PW-1:0]        FRAC_MASK = PW'((64'd1 << PHASE_FRAC_BITS) - 64'd1);
    localparam int PHASE_UP = CYC_BITS - PHASE_FRAC_BITS;

    // shape limits, Q8.8: 100 percent and a morph of 3
    localparam logic signed [15:0] SHAPE_PCT_MAX   = 16'sd25600;
    localparam logic signed [15:0] SHAPE_MORPH_MAX = 16'sd768;

    // morph = (768*s + 50) / 100, i.e. 0.03 * s rounded half up in Q16
    localparam int NUM_BITS = 25;
    localparam logic [NUM_BITS-1:0] MORPH_SCALE = 25'd768;
    localparam logic [NUM_BITS-1:0] MORPH_BIAS  = 25'd50;
    // ceil(2^32 / 100): exact quotient for every numerator below 2^25
    localparam int RECIP_SHIFT = 32;
    localparam logic [25:0] MORPH_RECIP = 26'd42949673;
    localparam int MPROD_BITS = NUM_BITS + 26;

    // wave order along the morph axis
    localparam logic [1:0] WAVE_SINE   = 2'd0;
    localparam logic [1:0] WAVE_SAW    = 2'd1;
    localparam logic [1:0] WAVE_TRI    = 2'd2;
    localparam logic [1:0] WAVE_SQUARE = 2'd3;

    // output rounding and saturation
    localparam int RSH = 30 - OUT_FRAC_BITS;
    localparam logic signed [WAVE_BITS:0] ROUND_HALF = 33'sd1 <<< (RSH - 1);
    localparam logic signed [WAVE_BITS:0] LEVEL_MAX  = 33'sd32767;
    localparam logic signed [WAVE_BITS:0] LEVEL_MIN  = -33'sd32768;

    // ---------------- stage 1: clamps, phase to cycle fraction ----------------
    logic signed [PW-1:0]  phase_x;
    logic [PW-1:0]         pc;
    logic [CYC_BITS-1:0]   cyc_next;
    logic [CYC_BITS-1:0]   fade_next;
    logic [14:0]           s_pct;
    logic [9:0]            s_morph;
    logic [NUM_BITS-1:0]   mnum_next;

    logic                  v_s1_reg;
    logic                  func_s1_reg;
    logic [CYC_BITS-1:0]   cyc_s1_reg;
    logic [CYC_BITS-1:0]   fade_s1_reg;
    logic [NUM_BITS-1:0]   mnum_s1_reg;

    always_comb
    begin
        phase_x = PW'(phase);
        // window mode holds phase to 0..1
        if (phase_x < 0)
        begin
            pc = '0;
        end
        else if (phase_x > P_ONE)
        begin
            pc = P_ONE;
        end
        else
        begin
            pc = phase_x;
        end

        if (func == FUNC_WINDOW)
        begin
            cyc_next = CYC_BITS'((pc & FRAC_MASK) << PHASE_UP);
        end
        else
        begin
            // wrap by floor: two's complement low bits already do it
            cyc_next = CYC_BITS'((PW'(phase) & FRAC_MASK) << PHASE_UP);
        end
        // edge fade runs over half a cycle
        fade_next = CYC_BITS'((pc << PHASE_UP) >> 1);

        if (shape < 0)
        begin
            s_pct = '0;
        end
        else if (shape > SHAPE_PCT_MAX)
        begin
            s_pct = 15'(SHAPE_PCT_MAX);
        end
        else
        begin
            s_pct = 15'(shape);
        end

        if (shape < 0)
        begin
            s_morph = '0;
        end
        else if (shape > SHAPE_MORPH_MAX)
        begin
            s_morph = 10'(SHAPE_MORPH_MAX);
        end
        else
        begin
            s_morph = 10'(shape);
        end

        if (func == FUNC_WINDOW)
        begin
            // shape is the morph directly, Q8.8 to Q16
            mnum_next = NUM_BITS'({s_morph, 8'd0});
        end
        else
        begin
            mnum_next = NUM_BITS'(s_pct) * MORPH_SCALE + MORPH_BIAS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_s1_reg <= 1'b0;
        end
        else
        begin
            v_s1_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        func_s1_reg <= func;
        cyc_s1_reg  <= cyc_next;
        fade_s1_reg <= fade_next;
        mnum_s1_reg <= mnum_next;
    end

    // ---------------- stages 2..3: two sine lookups ----------------
    wave_t sine_s3;
    wave_t fade_s3;

    msw_sine u_wave_sine (
        .clk  (clk),
        .cyc  (cyc_s1_reg),
        .sine (sine_s3)
    );

    msw_sine u_fade_sine (
        .clk  (clk),
        .cyc  (fade_s1_reg),
        .sine (fade_s3)
    );

    // ---------------- stage 2: percent to morph position ----------------
    logic [MPROD_BITS-1:0]  mprod;
    logic [MORPH_BITS-1:0]  m_next;

    logic                   v_s2_reg;
    logic                   func_s2_reg;
    logic [CYC_BITS-1:0]    cyc_s2_reg;
    logic [MORPH_BITS-1:0]  m_s2_reg;

    always_comb
    begin
        mprod = MPROD_BITS'(mnum_s1_reg) * MPROD_BITS'(MORPH_RECIP);
        if (func_s1_reg == FUNC_WINDOW)
        begin
            m_next = MORPH_BITS'(mnum_s1_reg);
        end
        else
        begin
            m_next = MORPH_BITS'(mprod >> RECIP_SHIFT);
        end
    end

    always_ff @(posedge clk)
    begin
        func_s2_reg <= func_s1_reg;
        cyc_s2_reg  <= cyc_s1_reg;
        m_s2_reg    <= m_next;
    end

    // ---------------- stage 3: saw, triangle, square ----------------
    logic signed [CYC_BITS:0] tdist;
    logic [CYC_BITS-1:0]      tabs;
    wave_t                    saw_next;
    wave_t                    tri_next;
    wave_t                    sq_next;

    logic                     v_s3_reg;
    logic                     func_s3_reg;
    logic [MORPH_BITS-1:0]    m_s3_reg;
    wave_t                    saw_s3_reg;
    wave_t                    tri_s3_reg;
    wave_t                    sq_s3_reg;

    always_comb
    begin
        saw_next = (WAVE_BITS'(cyc_s2_reg) << 7) - Q_ONE;
        tdist = $signed({1'b0, cyc_s2_reg}) - (25'sd1 <<< (CYC_BITS - 1));
        if (tdist < 0)
        begin
            tabs = CYC_BITS'(-tdist);
        end
        else
        begin
            tabs = CYC_BITS'(tdist);
        end
        tri_next = Q_ONE - (WAVE_BITS'(tabs) << 8);
        // high for the first half cycle
        sq_next  = cyc_s2_reg[CYC_BITS-1] ? -Q_ONE : Q_ONE;
    end

    always_ff @(posedge clk)
    begin
        func_s3_reg <= func_s2_reg;
        m_s3_reg    <= m_s2_reg;
        saw_s3_reg  <= saw_next;
        tri_s3_reg  <= tri_next;
        sq_s3_reg   <= sq_next;
    end

    // ---------------- stage 4: blend neighbor waves ----------------
    function automatic wave_t pick_wave(
        input logic [1:0] sel,
        input wave_t      w_sine,
        input wave_t      w_saw,
        input wave_t      w_tri,
        input wave_t      w_sq
    );
        wave_t w;
        case (sel)
            WAVE_SINE: w = w_sine;
            WAVE_SAW:  w = w_saw;
            WAVE_TRI:  w = w_tri;
            default:   w = w_sq;
        endcase
        return w;
    endfunction

    logic [1:0]                 left;
    logic [1:0]                 right;
    logic [15:0]                blend;
    wave_t                      wl;
    wave_t                      wr;
    logic signed [WAVE_BITS:0]  wdiff;
    logic signed [49:0]         bprod;
    wave_t                      bip_next;

    logic                       v_s4_reg;
    logic                       func_s4_reg;
    wave_t                      bip_s4_reg;
    wave_t                      fade_s4_reg;

    always_comb
    begin
        // morph never exceeds 3.0, so the top bits are the left wave
        left  = m_s3_reg[MORPH_BITS-1 -: 2];
        blend = m_s3_reg[15:0];
        if (left == WAVE_SQUARE)
        begin
            right = WAVE_SQUARE;
        end
        else
        begin
            right = left + 2'd1;
        end
        wl = pick_wave(left, sine_s3, saw_s3_reg, tri_s3_reg, sq_s3_reg);
        wr = pick_wave(right, sine_s3, saw_s3_reg, tri_s3_reg, sq_s3_reg);
        wdiff = (WAVE_BITS+1)'(wr) - (WAVE_BITS+1)'(wl);
        bprod = 50'(wdiff) * 50'($signed({1'b0, blend}));
        bip_next = wl + WAVE_BITS'(bprod >>> 16);
    end

    always_ff @(posedge clk)
    begin
        func_s4_reg <= func_s3_reg;
        bip_s4_reg  <= bip_next;
        fade_s4_reg <= fade_s3;
    end

    // ---------------- stage 5: unipolar wave times edge fade ----------------
    logic signed [WAVE_BITS:0]   usum;
    logic signed [WAVE_BITS:0]   uhalf;
    logic [ROM_BITS-1:0]         uni;
    logic [ROM_BITS-1:0]         fade;
    logic [2*ROM_BITS-1:0]       wprod;
    logic [2*ROM_BITS-1:0]       wscaled;
    wave_t                       win_val;
    wave_t                       val_next;

    logic                        v_s5_reg;
    wave_t                       val_s5_reg;

    always_comb
    begin
        usum  = (WAVE_BITS+1)'(bip_s4_reg) + (WAVE_BITS+1)'(Q_ONE);
        uhalf = usum >>> 1;
        uni   = (uhalf < 0) ? '0 : ROM_BITS'(uhalf);
        fade  = (fade_s4_reg < 0) ? '0 : ROM_BITS'(fade_s4_reg);
        wprod = (2*ROM_BITS)'(uni) * (2*ROM_BITS)'(fade);
        wscaled = wprod >> 30;
        if (wscaled > (2*ROM_BITS)'(Q_ONE))
        begin
            win_val = Q_ONE;
        end
        else
        begin
            win_val = WAVE_BITS'(wscaled);
        end
        val_next = (func_s4_reg == FUNC_WINDOW) ? win_val : bip_s4_reg;
    end

    always_ff @(posedge clk)
    begin
        val_s5_reg <= val_next;
    end

    // ---------------- stage 6: round half up, saturate ----------------
    logic signed [WAVE_BITS:0] rsum;
    logic signed [WAVE_BITS:0] rsh;
    logic signed [15:0]        level_next;
    logic signed [15:0]        level_reg;
    logic                      done_reg;

    always_comb
    begin
        rsum = (WAVE_BITS+1)'(val_s5_reg) + ROUND_HALF;
        rsh  = rsum >>> RSH;
        if (rsh > LEVEL_MAX)
        begin
            level_next = 16'(LEVEL_MAX);
        end
        else if (rsh < LEVEL_MIN)
        begin
            level_next = 16'(LEVEL_MIN);
        end
        else
        begin
            level_next = 16'(rsh);
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
    end

    // valid bits travel with the items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_s2_reg <= 1'b0;
            v_s3_reg <= 1'b0;
            v_s4_reg <= 1'b0;
            v_s5_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_s2_reg <= v_s1_reg;
            v_s3_reg <= v_s2_reg;
            v_s4_reg <= v_s3_reg;
            v_s5_reg <= v_s4_reg;
            done_reg <= v_s5_reg;
        end
    end

    assign busy  = 1'b0;
    assign done  = done_reg;
    assign level = level_reg;

    // ---------------- checks ----------------
    // every accepted item comes out as a done
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 done)
        else $error("accepted item did not produce a result");

    // no result without an accepted item in front of it
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 6))
        else $error("result without an accepted item");

    // the grain window is never negative
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_WINDOW) |-> ##6 !level[15])
        else $error("negative window level");

endmodule

// ===== rtl/msw_sine.sv =====
module msw_sine (
    input  logic                          clk,
    input  logic [msw_pkg::CYC_BITS-1:0]  cyc,
    output msw_pkg::wave_t                sine
);
    import msw_pkg::*;

    logic [1:0]           quad;
    logic [POS_BITS-1:0]  pos;
    logic [IDX_BITS-1:0]  idx;
    logic [IDX_BITS-1:0]  nxt;

    logic [ROM_BITS-1:0]  e0_reg;
    logic [ROM_BITS-1:0]  e1_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic                 neg_reg;

    logic signed [WAVE_BITS-1:0]             diff;
    logic signed [WAVE_BITS+FRAC_BITS:0]     prod;
    wave_t                                   mag;
    wave_t                                   sine_next;
    wave_t                                   sine_reg;

    // fold the quadrant onto the table
    always_comb
    begin
        quad = cyc[CYC_BITS-1 -: 2];
        if (quad[0])
        begin
            pos = POS_BITS'(1 << QUAD_BITS) - POS_BITS'(cyc[QUAD_BITS-1:0]);
        end
        else
        begin
            pos = POS_BITS'(cyc[QUAD_BITS-1:0]);
        end
        idx = pos[POS_BITS-1 -: IDX_BITS];
        if (idx == IDX_BITS'(SINE_TOP))
        begin
            nxt = idx;
        end
        else
        begin
            nxt = idx + IDX_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg   <= SINE_ROM[idx];
        e1_reg   <= SINE_ROM[nxt];
        frac_reg <= pos[FRAC_BITS-1:0];
        neg_reg  <= quad[1];
    end

    // linear interpolation between neighbor entries
    always_comb
    begin
        diff = WAVE_BITS'(e1_reg) - WAVE_BITS'(e0_reg);
        prod = (WAVE_BITS+FRAC_BITS+1)'(diff)
             * (WAVE_BITS+FRAC_BITS+1)'($signed({1'b0, frac_reg}));
        mag  = WAVE_BITS'(e0_reg) + WAVE_BITS'(prod >>> FRAC_BITS);
        sine_next = neg_reg ? -mag : mag;
    end

    always_ff @(posedge clk)
    begin
        sine_reg <= sine_next;
    end

    assign sine = sine_reg;

endmodule

// ===== test/shape_level_checker.sv =====
module shape_level_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               func,
    input  logic signed [23:0] phase,
    input  logic signed [15:0] shape,
    input  logic               done,
    input  logic signed [15:0] level,
    output int                 mismatches,
    output int                 outstanding
);
    import msw_pkg::*;

    localparam longint          UNITY   = 64'sd1 <<< 30;
    localparam longint unsigned UNITY_U = 64'd1 << 30;
    localparam int              INTERP  = QUAD_BITS - SINE_TABLE_BITS;
    localparam longint          PH_ONE  = 64'sd1 <<< PHASE_FRAC_BITS;
    localparam int              PH_UP   = CYC_BITS - PHASE_FRAC_BITS;

    typedef struct {
        logic               fsel;
        logic signed [23:0] ph;
        logic signed [15:0] sh;
        logic signed [15:0] lvl;
    } level_due_t;

    level_due_t levels_due [$];
    level_due_t head;
    level_due_t taken;
    longint     quarter_sine [0:SINE_TOP];

    // truncated series for sin over a quarter turn, Q2.30
    function automatic longint unsigned sine_entry(input longint unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned d;
        int              k;
        x  = (i * HALF_PI_Q30) >> SINE_TABLE_BITS;
        x2 = (x * x) >> 30;
        t  = UNITY_U;
        for (k = 7; k >= 1; k--)
        begin
            d = longint'(2 * k) * longint'(2 * k + 1);
            t = UNITY_U - ((x2 * t) >> 30) / d;
        end
        t = (x * t) >> 30;
        if (t > UNITY_U)
        begin
            t = UNITY_U;
        end
        return t;
    endfunction

    // full-cycle sine from the quarter table with linear interpolation
    function automatic longint sine_of(input logic [CYC_BITS-1:0] f);
        logic [1:0]      quad;
        longint unsigned pos;
        longint unsigned idx;
        longint unsigned frac;
        longint unsigned nxt;
        longint          e0;
        longint          e1;
        longint          v;
        quad = f[CYC_BITS-1 -: 2];
        pos  = f[QUAD_BITS-1:0];
        if (quad[0])
        begin
            pos = (64'd1 << QUAD_BITS) - pos;
        end
        idx  = pos >> INTERP;
        frac = pos & ((64'd1 << INTERP) - 1);
        nxt  = (idx + 1 > SINE_TOP) ? SINE_TOP : idx + 1;
        e0   = quarter_sine[idx];
        e1   = quarter_sine[nxt];
        v    = e0 + (((e1 - e0) * longint'(frac)) >>> INTERP);
        return quad[1] ? -v : v;
    endfunction

    // sine, saw, triangle, square; m is a Q16 position 0..3
    function automatic longint blend_wave(input logic [CYC_BITS-1:0] f, input longint m);
        longint wv [4];
        longint d;
        longint mix;
        int     lo;
        int     hi;
        d = longint'(f) - (64'sd1 <<< (CYC_BITS - 1));
        if (d < 0)
        begin
            d = -d;
        end
        wv[0] = sine_of(f);
        wv[1] = (longint'(f) <<< 7) - UNITY;
        wv[2] = UNITY - (d <<< 8);
        wv[3] = f[CYC_BITS-1] ? -UNITY : UNITY;
        lo    = int'(m >>> 16);
        if (lo > 3)
        begin
            lo = 3;
        end
        hi  = (lo + 1 > 3) ? 3 : lo + 1;
        mix = m - (longint'(lo) <<< 16);
        return wv[lo] + (((wv[hi] - wv[lo]) * mix) >>> 16);
    endfunction

    function automatic logic signed [15:0] predict_level(
        input logic               fsel,
        input logic signed [23:0] ph,
        input logic signed [15:0] sh
    );
        longint              p;
        longint              s;
        longint              bip;
        longint              uni;
        longint              fade;
        longint              val;
        longint              r;
        logic [CYC_BITS-1:0] f;
        p = ph;
        s = sh;
        if (fsel == FUNC_WAVE)
        begin
            if (s < 0)
            begin
                s = 0;
            end
            if (s > 25600)
            begin
                s = 25600;
            end
            f   = CYC_BITS'((p & (PH_ONE - 1)) <<< PH_UP);
            val = blend_wave(f, (s * 196608 + 12800) / 25600);
        end
        else
        begin
            if (p < 0)
            begin
                p = 0;
            end
            if (p > PH_ONE)
            begin
                p = PH_ONE;
            end
            if (s < 0)
            begin
                s = 0;
            end
            if (s > 768)
            begin
                s = 768;
            end
            f    = CYC_BITS'((p & (PH_ONE - 1)) <<< PH_UP);
            bip  = blend_wave(f, s <<< 8);
            uni  = (bip + UNITY) >>> 1;
            // half-cycle fade, phase of one lands on sin(pi)
            fade = sine_of(CYC_BITS'((p <<< PH_UP) >>> 1));
            if (uni < 0)
            begin
                uni = 0;
            end
            if (fade < 0)
            begin
                fade = 0;
            end
            val = (uni * fade) >>> 30;
            if (val > UNITY)
            begin
                val = UNITY;
            end
        end
        r = (val + (64'sd1 <<< (29 - OUT_FRAC_BITS))) >>> (30 - OUT_FRAC_BITS);
        if (r > 32767)
        begin
            r = 32767;
        end
        if (r < -32768)
        begin
            r = -32768;
        end
        return r[15:0];
    endfunction

    task automatic flag_level(input string why, input logic signed [15:0] got,
                              input level_due_t want);
        if (mismatches < 50)
        begin
            $display("%s: func=%0d phase=%0d shape=%0d level=%0d expected=%0d",
                     why, want.fsel, want.ph, want.sh, got, want.lvl);
        end
        mismatches++;
    endtask

    initial
    begin
        int i;
        for (i = 0; i <= SINE_TOP; i++)
        begin
            quarter_sine[i] = longint'(sine_entry(64'(i)));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (levels_due.size() == 0)
                begin
                    flag_level("level with no item outstanding", level,
                               '{fsel: 1'b0, ph: '0, sh: '0, lvl: '0});
                end
                else
                begin
                    head = levels_due.pop_front();
                    if (level !== head.lvl)
                    begin
                        flag_level("wrong level", level, head);
                    end
                end
            end
            if (start && !busy)
            begin
                taken.fsel = func;
                taken.ph   = phase;
                taken.sh   = shape;
                taken.lvl  = predict_level(func, phase, shape);
                levels_due.push_back(taken);
            end
        end
        outstanding = levels_due.size();
    end

endmodule

// ===== test/tb.sv =====
module tb;
    import msw_pkg::*;

    // cycles with neither an item taken nor a level returned before giving up
    localparam int STALL_LIMIT = 2000;
    // random items per pacing phase
    localparam int PHASE_ITEMS = 509;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               func  = FUNC_WAVE;
    logic signed [23:0] phase = '0;
    logic signed [15:0] shape = '0;
    logic               busy;
    logic               done;
    logic signed [15:0] level;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;
    // chance in a hundred that the sender leaves a gap before an item, drawn anew while the gap runs
    int idle_pct = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    morphing_shape_waveform dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .func  (func),
        .phase (phase),
        .shape (shape),
        .done  (done),
        .level (level)
    );

    // predicts every level from the items it sees taken and compares
    shape_level_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .phase       (phase),
        .shape       (shape),
        .done        (done),
        .level       (level),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // present one item at a falling edge and hold it until it is taken;
    // busy only moves on rising edges, so its value at the falling edge is
    // the one the next rising edge sees
    task automatic send_item(input logic fsel, input logic signed [23:0] ph,
                             input logic signed [15:0] sh);
        logic was_busy;
        // random gap in front of the item
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        func  <= fsel;
        phase <= ph;
        shape <= sh;
        forever
        begin
            was_busy = busy;
            @(posedge clk);
            if (!was_busy)
            begin
                break;
            end
            @(negedge clk);
        end
    endtask

    // watchdog: a hung pipeline or a lost level stops the run here
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("morphing_shape_waveform: mismatch");
            $finish;
        end
    end

    initial
    begin
        int                 n;
        int                 k;
        int                 pick;
        logic               fsel;
        logic signed [23:0] ph;
        logic signed [15:0] sh;

        // hold reset, then release it between edges
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // directed: sine peak and trough, negative phase wrapping by floor
        send_item(FUNC_WAVE, 24'sh000000, 16'sd0);
        send_item(FUNC_WAVE, 24'sh004000, 16'sd0);
        send_item(FUNC_WAVE, 24'sh00C000, 16'sd0);
        send_item(FUNC_WAVE, 24'shFFC000, 16'sd0);
        // blends around saw and triangle, percent in Q8.8
        send_item(FUNC_WAVE, 24'sh002000, 16'sd8533);
        send_item(FUNC_WAVE, 24'sh006000, 16'sd17067);
        send_item(FUNC_WAVE, 24'sh00FFFF, 16'sd4267);
        send_item(FUNC_WAVE, 24'sh008000, 16'sd12800);
        // full square: +1.0 saturates, -1.0 is the bottom code
        send_item(FUNC_WAVE, 24'sh002000, 16'sd25600);
        send_item(FUNC_WAVE, 24'sh009000, 16'sd25600);
        // field extremes, shape clamped both ways
        send_item(FUNC_WAVE, 24'sh7FFFFF, 16'sh7FFF);
        send_item(FUNC_WAVE, 24'sh800000, 16'sh8000);
        // window: zero fade at both ends, phase of exactly one wraps the wave
        send_item(FUNC_WINDOW, 24'sh000000, 16'sd0);
        send_item(FUNC_WINDOW, 24'sh010000, 16'sd768);
        send_item(FUNC_WINDOW, 24'sh008000, 16'sd0);
        send_item(FUNC_WINDOW, 24'sh008000, 16'sd768);
        send_item(FUNC_WINDOW, 24'sh004000, 16'sd256);
        send_item(FUNC_WINDOW, 24'sh00C000, 16'sd384);
        send_item(FUNC_WINDOW, 24'sh00FFFF, 16'sd767);
        // window phase and shape out of range
        send_item(FUNC_WINDOW, 24'shFF0000, 16'sd512);
        send_item(FUNC_WINDOW, 24'sh7FFFFF, 16'sd100);
        send_item(FUNC_WINDOW, 24'sh00A000, 16'sh7FFF);
        send_item(FUNC_WINDOW, 24'sh003000, 16'sh8000);

        // random part in three pacing phases: light gaps, heavy gaps, none
        for (n = 0; n < 3; n++)
        begin
            idle_pct = (n == 0) ? 34 : ((n == 1) ? 55 : 0);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                fsel = 1'($urandom_range(1));
                // phase: anything, the useful window around 0..1, or quarter points
                pick = int'($urandom_range(9));
                if (pick < 3)
                begin
                    ph = 24'($urandom);
                end
                else if (pick < 8)
                begin
                    ph = 24'($urandom_range(32'h40000) - 32'h20000);
                end
                else
                begin
                    ph = 24'(($urandom_range(8) << 14) + $urandom_range(2) - 1);
                end
                // shape: anything, the legal range of the mode, or near a wave
                pick = int'($urandom_range(9));
                if (pick < 3)
                begin
                    sh = 16'($urandom);
                end
                else if (pick < 8)
                begin
                    sh = (fsel == FUNC_WAVE) ? 16'($urandom_range(25600))
                                             : 16'($urandom_range(768));
                end
                else if (fsel == FUNC_WAVE)
                begin
                    sh = 16'($urandom_range(3) * 8533 + $urandom_range(2));
                end
                else
                begin
                    sh = 16'($urandom_range(3) * 256 + $urandom_range(2) - 1);
                end
                send_item(fsel, ph, sh);
            end
            // sender holds off until every level is back
            @(negedge clk);
            start <= 1'b0;
            while (outstanding != 0)
            begin
                @(negedge clk);
            end
        end

        // wait past the pipeline depth to catch stray levels
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("morphing_shape_waveform: match");
        end
        else
        begin
            $display("morphing_shape_waveform: mismatch");
        end
        $finish;
    end

endmodule
